@@ sv/jfse_pkg.sv @@
// jfse_pkg: shared types, constants and helper functions of the JSON field string extractor.
// No dependencies; every other file of the block imports it.
package jfse_pkg;

    localparam int MAX_KEY    = 16;
    localparam int WIN_CELLS  = MAX_KEY + 1;
    localparam int KEY_LEN_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CNT_W      = 16;
    localparam int KEY_W      = 16 * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JSON_MODE  = 3'd0,
        CFG_MIN_LENGTH = 3'd1,
        CFG_KEY_LENGTH = 3'd2,
        CFG_KEY_FIRST  = 3'd3,
        CFG_KEY_LAST   = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_KEY,
        PH_COLON,
        PH_QUOTE,
        PH_STR,
        PH_ESC,
        PH_HEX,
        PH_DONE
    } phase_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [15:0] CP_ONE_LIM = 16'h0080;
    localparam logic [15:0] CP_TWO_LIM = 16'h0800;
    localparam logic [7:0]  UTF_LEAD2  = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3  = 8'hE0;
    localparam logic [7:0]  UTF_CONT   = 8'h80;

    typedef struct packed {
        logic       shift;
        logic       clr;
    } cell_ctl_t;

    typedef struct packed {
        logic       care;
        logic [7:0] ch;
    } key_exp_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_t;

    typedef struct packed {
        phase_t     phase;
        logic       emit;
        logic [7:0] ch;
        logic       to_hex;
    } feed_t;

    // results of one item: up to three bytes plus line-end flags
    typedef struct packed {
        logic [1:0]      n;
        logic [2:0][7:0] bytes;
        logic            last;
        logic            found;
        logic            long_enough;
        logic            err;
    } result_t;

    // expected byte for window cell p, given the saturated key length
    function automatic key_exp_t key_expect(int p, logic [KEY_LEN_W-1:0] len,
                                            logic [KEY_W-1:0] key);
        key_exp_t e;
        int       base;
        int       idx;
        e.care = 1'b0;
        e.ch   = 8'h00;
        base   = WIN_CELLS - int'(len);
        idx    = p - base;
        if (p == base - 1) begin
            e.care = 1'b1;
            e.ch   = CH_QUOTE;
        end else if (p >= base) begin
            e.care = 1'b1;
            e.ch   = key[idx*8 +: 8];
        end
        return e;
    endfunction

    function automatic hex_t hex_val(logic [7:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.nib = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.nib = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.ok  = 1'b1;
            h.nib = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok  = 1'b1;
            h.nib = 4'(c - 8'h37);
        end
        return h;
    endfunction

    // one string byte in string or escape phase
    function automatic feed_t feed_str(phase_t ph, logic [7:0] b, logic last);
        feed_t f;
        f.phase  = ph;
        f.emit   = 1'b0;
        f.ch     = b;
        f.to_hex = 1'b0;
        unique case (ph)
            PH_STR:
            begin
                if (b == CH_QUOTE) begin
                    f.phase = PH_DONE;
                end else if (b == CH_BSLASH) begin
                    if (last) begin
                        f.emit = 1'b1;
                    end else begin
                        f.phase = PH_ESC;
                    end
                end else begin
                    f.emit = 1'b1;
                end
            end
            PH_ESC:
            begin
                f.phase = PH_STR;
                unique case (b)
                    CH_N:
                    begin
                        f.emit = 1'b1;
                        f.ch   = CH_LF;
                    end
                    CH_T:
                    begin
                        f.emit = 1'b1;
                        f.ch   = CH_TAB;
                    end
                    CH_R:
                    begin
                        f.emit = 1'b1;
                        f.ch   = CH_CR;
                    end
                    CH_U:
                    begin
                        if (!last) begin
                            f.phase  = PH_HEX;
                            f.to_hex = 1'b1;
                        end
                    end
                    default:
                    begin
                        f.emit = 1'b1;
                    end
                endcase
            end
            default:
            begin
                f.phase = ph;
            end
        endcase
        return f;
    endfunction

endpackage

@@ sv/jfse_ifs.sv @@
// jfse_ifs: valid/ready channel interfaces for line bytes, results and register writes.
// Depends on jfse_pkg.
interface jfse_line_if import jfse_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       line_end;

    modport source (output valid, in_byte, line_end, input ready);
    modport sink   (input valid, in_byte, line_end, output ready);
endinterface

interface jfse_result_if import jfse_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       doc_end;
    logic       field_found;
    logic       long_enough;
    logic       escape_error;

    modport source (output valid, out_byte, byte_valid, doc_end, field_found, long_enough,
                    escape_error, input ready);
    modport sink   (input valid, out_byte, byte_valid, doc_end, field_found, long_enough,
                    escape_error, output ready);
endinterface

interface jfse_cfg_if import jfse_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/json_field_string_extractor_unit.sv @@
// JSON field string extractor: first result valid the cycle after a byte is accepted.
// One byte per cycle if the output is ready; an item of k results (k up to 3) holds the
// input until its last result leaves the single output buffer, one result per cycle
// while ready. Reset: registers default (JSON mode, key length 4), parse state and key
// window clear, output buffer empty. Depends on jfse_pkg, jfse_ifs and the jfse modules.
module json_field_string_extractor_unit import jfse_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    jfse_line_if.sink     line_ch,
    jfse_result_if.source result_ch,
    jfse_cfg_if.sink      cfg_ch
);

    logic                 json_mode_reg;
    logic [15:0]          min_length_reg;
    logic [KEY_LEN_W-1:0] key_length_reg;
    logic [63:0]          key_first_reg;
    logic [63:0]          key_last_reg;
    logic [KEY_LEN_W-1:0] key_len_sat;

    logic                 take;
    logic                 key_phase;
    logic                 key_match;
    cell_ctl_t            cell_ctl;
    result_t              res;
    logic [7:0]           win [WIN_CELLS];
    logic [WIN_CELLS-1:0] cell_ok;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            json_mode_reg  <= 1'b1;
            min_length_reg <= 16'd0;
            key_length_reg <= KEY_LEN_W'(4);
            key_first_reg  <= 64'd0;
            key_last_reg   <= 64'd0;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                CFG_JSON_MODE:  json_mode_reg  <= cfg_ch.data[0];
                CFG_MIN_LENGTH: min_length_reg <= cfg_ch.data[15:0];
                CFG_KEY_LENGTH: key_length_reg <= cfg_ch.data[KEY_LEN_W-1:0];
                CFG_KEY_FIRST:  key_first_reg  <= cfg_ch.data;
                CFG_KEY_LAST:   key_last_reg   <= cfg_ch.data;
                default:        ;
            endcase
        end
    end

    assign key_len_sat = (key_length_reg > KEY_LEN_W'(MAX_KEY)) ? KEY_LEN_W'(MAX_KEY)
                                                                  : key_length_reg;

    assign take           = line_ch.valid && line_ch.ready;
    assign cell_ctl.shift = take && json_mode_reg && key_phase;
    assign cell_ctl.clr   = take && line_ch.line_end;

    for (genvar p = 0; p < WIN_CELLS; p++) begin : g_cell
        key_exp_t   exp_ch;
        logic [7:0] din;

        assign exp_ch = key_expect(p, key_len_sat, {key_last_reg, key_first_reg});

        if (p == WIN_CELLS - 1) begin : g_tail
            assign din = line_ch.in_byte;
        end else begin : g_body
            assign din = win[p+1];
        end

        jfse_key_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl),
            .din       (din),
            .expect_ch (exp_ch),
            .dout      (win[p]),
            .ok        (cell_ok[p])
        );
    end

    assign key_match = (line_ch.in_byte == CH_QUOTE) && (&cell_ok);

    jfse_decoder u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .in_byte    (line_ch.in_byte),
        .line_end   (line_ch.line_end),
        .json_mode  (json_mode_reg),
        .min_length (min_length_reg),
        .key_match  (key_match),
        .key_phase  (key_phase),
        .res        (res)
    );

    jfse_out_buf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .res_in    (res),
        .ready_in  (line_ch.ready),
        .result_ch (result_ch)
    );

endmodule

@@ sv/jfse_key_cell.sv @@
// jfse_key_cell: one byte of the key search window; shifts toward its neighbor and
// compares its byte with the expected key character. Depends on jfse_pkg.
module jfse_key_cell import jfse_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  logic [7:0] din,
    input  key_exp_t   expect_ch,
    output logic [7:0] dout,
    output logic       ok
);

    logic [7:0] val_reg;
    logic [7:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.clr) begin
            val_next = 8'h00;
        end else if (ctl.shift) begin
            val_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            val_reg <= 8'h00;
        end else begin
            val_reg <= val_next;
        end
    end

    assign dout = val_reg;
    assign ok   = !expect_ch.care || (val_reg == expect_ch.ch);

endmodule

@@ sv/jfse_decoder.sv @@
// jfse_decoder: parse phase, string unescape and \u to UTF-8 conversion, decoded count.
// Produces the results of one accepted item. Depends on jfse_pkg.
module jfse_decoder import jfse_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  in_byte,
    input  logic        line_end,
    input  logic        json_mode,
    input  logic [15:0] min_length,
    input  logic        key_match,
    output logic        key_phase,
    output result_t     res
);

    phase_t          phase_reg;
    phase_t          phase_next;
    logic [1:0]      hcnt_reg;
    logic [1:0]      hcnt_next;
    logic [7:0]      hd_reg [3];
    logic            hd_we;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic            err_reg;
    logic            err_next;

    hex_t            h0, h1, h2, h3;
    logic [15:0]     cp;
    logic [1:0]      u_n;
    logic [2:0][7:0] u_em;
    logic [3:0][7:0] em;
    logic [1:0]      n;
    logic [CNT_W:0]  sum;
    feed_t           f;
    phase_t          ip;
    logic [7:0]      bj;

    assign key_phase = (phase_reg == PH_KEY);

    // unicode escape from three stored digits and the current byte
    always_comb
    begin
        h0 = hex_val(hd_reg[0]);
        h1 = hex_val(hd_reg[1]);
        h2 = hex_val(hd_reg[2]);
        h3 = hex_val(in_byte);
        if (!h1.ok) begin
            cp = {12'h000, h0.nib};
        end else if (!h2.ok) begin
            cp = {8'h00, h0.nib, h1.nib};
        end else if (!h3.ok) begin
            cp = {4'h0, h0.nib, h1.nib, h2.nib};
        end else begin
            cp = {h0.nib, h1.nib, h2.nib, h3.nib};
        end
        u_em = '0;
        if (cp < CP_ONE_LIM) begin
            u_n     = 2'd1;
            u_em[0] = cp[7:0];
        end else if (cp < CP_TWO_LIM) begin
            u_n     = 2'd2;
            u_em[0] = UTF_LEAD2 | {3'b000, cp[10:6]};
            u_em[1] = UTF_CONT | {2'b00, cp[5:0]};
        end else begin
            u_n     = 2'd3;
            u_em[0] = UTF_LEAD3 | {4'h0, cp[15:12]};
            u_em[1] = UTF_CONT | {2'b00, cp[11:6]};
            u_em[2] = UTF_CONT | {2'b00, cp[5:0]};
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        hcnt_next  = hcnt_reg;
        hd_we      = 1'b0;
        err_next   = err_reg;
        em         = '0;
        n          = 2'd0;
        f          = feed_str(PH_STR, in_byte, line_end);
        ip         = PH_STR;
        bj         = in_byte;
        if (!json_mode) begin
            em[0] = in_byte;
            n     = 2'd1;
        end else begin
            unique case (phase_reg)
                PH_KEY:
                begin
                    if (key_match) begin
                        phase_next = PH_COLON;
                    end
                end
                PH_COLON:
                begin
                    if (in_byte == CH_COLON) begin
                        phase_next = PH_QUOTE;
                    end
                end
                PH_QUOTE:
                begin
                    if (in_byte == CH_QUOTE) begin
                        phase_next = PH_STR;
                    end
                end
                PH_STR, PH_ESC:
                begin
                    f          = feed_str(phase_reg, in_byte, line_end);
                    phase_next = f.phase;
                    if (f.to_hex) begin
                        hcnt_next = 2'd0;
                    end
                    if (f.emit) begin
                        em[0] = f.ch;
                        n     = 2'd1;
                    end
                end
                PH_HEX:
                begin
                    if (hcnt_reg == 2'd3) begin
                        phase_next = PH_STR;
                        hcnt_next  = 2'd0;
                        if (!h0.ok) begin
                            err_next = 1'b1;
                        end else begin
                            em[2:0] = u_em;
                            n       = u_n;
                        end
                    end else if (line_end) begin
                        // truncated escape: replay the digits as plain string bytes
                        phase_next = PH_STR;
                        hcnt_next  = 2'd0;
                        for (int j = 0; j < 3; j++) begin
                            if (j <= int'(hcnt_reg)) begin
                                bj = (j == int'(hcnt_reg)) ? in_byte : hd_reg[j];
                                if (ip == PH_HEX) begin
                                    ip = PH_STR;
                                end
                                f  = feed_str(ip, bj, j == int'(hcnt_reg));
                                ip = f.phase;
                                if (f.emit) begin
                                    em[n] = f.ch;
                                    n     = n + 2'd1;
                                end
                            end
                        end
                    end else begin
                        hd_we     = 1'b1;
                        hcnt_next = hcnt_reg + 2'd1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        sum      = {1'b0, cnt_reg} + (CNT_W+1)'(n);
        cnt_next = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];

        res.n           = n;
        res.bytes       = em[2:0];
        res.last        = line_end;
        res.found       = !json_mode || phase_next == PH_STR || phase_next == PH_ESC
                          || phase_next == PH_HEX || phase_next == PH_DONE;
        res.long_enough = (cnt_next >= min_length);
        res.err         = json_mode & err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_KEY;
            hcnt_reg  <= 2'd0;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
        end else if (take) begin
            if (line_end) begin
                phase_reg <= PH_KEY;
                hcnt_reg  <= 2'd0;
                cnt_reg   <= '0;
                err_reg   <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                hcnt_reg  <= hcnt_next;
                cnt_reg   <= cnt_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && hd_we) begin
            hd_reg[hcnt_reg] <= in_byte;
        end
    end

endmodule

@@ sv/jfse_out_buf.sv @@
// jfse_out_buf: holds the results of one item and hands them out one per cycle while the result channel is ready.
// Depends on jfse_pkg and jfse_ifs.
module jfse_out_buf import jfse_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  result_t              res_in,
    output logic                 ready_in,
    jfse_result_if.source        result_ch
);

    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic [1:0]      total;
    logic [2:0][7:0] bytes_reg;
    logic            has_reg;
    logic            last_reg;
    logic            found_reg;
    logic            long_reg;
    logic            err_reg;
    logic            pop;
    logic            doc_end;

    assign total    = (res_in.n == 2'd0) ? {1'b0, res_in.last} : res_in.n;
    assign pop      = result_ch.valid && result_ch.ready;
    assign ready_in = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && result_ch.ready);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = total;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            bytes_reg <= res_in.bytes;
            has_reg   <= (res_in.n != 2'd0);
            last_reg  <= res_in.last;
            found_reg <= res_in.found;
            long_reg  <= res_in.long_enough;
            err_reg   <= res_in.err;
        end else if (pop) begin
            bytes_reg <= {8'h00, bytes_reg[2:1]};
        end
    end

    assign doc_end                = last_reg && (cnt_reg == 2'd1);
    assign result_ch.valid        = (cnt_reg != 2'd0);
    assign result_ch.out_byte     = has_reg ? bytes_reg[0] : 8'h00;
    assign result_ch.byte_valid   = has_reg;
    assign result_ch.doc_end      = doc_end;
    assign result_ch.field_found  = doc_end && found_reg;
    assign result_ch.long_enough  = doc_end && long_reg;
    assign result_ch.escape_error = doc_end && err_reg;

endmodule
